### hw/rtl/aalpc_pkg.sv
// Package for the average-at-least pair counter.
// Holds widths, defaults and the controller state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aalpc_pkg;
    localparam int MAX_ITEMS_DEF = 1024;
    localparam int VAL_W         = 16;
    localparam int CNT_W         = 20;
    localparam int PFX_W         = 28;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_LOAD,
        ST_PASS,
        ST_FETCH,
        ST_WAIT,
        ST_CMP,
        ST_COPY_RD,
        ST_COPY_WAIT,
        ST_COPY_WR,
        ST_EMIT
    } aalpc_state_t;
endpackage
`default_nettype wire

### hw/rtl/aalpc_ram.sv
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module aalpc_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1025,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/average_at_least_pair_counter.sv
// Average-at-least pair counter: prefix-sum load, then bottom-up merge count.
// The merge makes P = ceil(log2(n+1)) passes over the n+1 stored entries.
// Throughput: one value per cycle while loading; each merge pass compares elements
// through the fetch, wait and compare states and copies them back through the read,
// wait and write states, set by the single read port of each memory. Reset clears
// the count, the running sum and the threshold, then writes entry zero of the prefix
// memory in the init state before the first item is taken.
`timescale 1ns / 1ps
`default_nettype none
module average_at_least_pair_counter
    import aalpc_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [VAL_W-1:0]    cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [VAL_W-1:0]    s_value,
    input  wire logic                s_last,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [CNT_W-1:0]    m_pair_count,
    output logic                     m_overflow
);
    localparam int DEPTH = MAX_ITEMS + 1;
    localparam int AW    = $clog2(DEPTH + 1);
    localparam int PW    = VAL_W + 1 + $clog2(MAX_ITEMS + 1) + 1;

    aalpc_state_t st_reg, st_next;
    logic signed [VAL_W-1:0] thr_reg;
    logic signed [PW-1:0] run_reg;
    logic [AW-1:0] n_reg;          // stored values, entries 1..n
    logic drop_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [AW:0] width_reg;
    logic [AW:0] lo_reg, a_reg, b_reg, mid_reg, hi_reg, k_reg;
    logic [AW-1:0] placed_reg;
    logic signed [PW-1:0] va_reg;

    // Memory ports.
    logic p_we, s_we;
    logic [AW-1:0] p_wa, p_ra, s_wa, s_ra;
    logic [PW-1:0] p_wd, p_rd, s_wd, s_rd;

    aalpc_ram #(.WIDTH(PW), .DEPTH(DEPTH + 1), .AW(AW)) u_pfx (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    aalpc_ram #(.WIDTH(PW), .DEPTH(DEPTH + 1), .AW(AW)) u_scr (
        .aclk(aclk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

    logic [AW:0] total;
    logic signed [PW-1:0] nxt_pfx;
    logic a_ok, b_ok, take_a;
    assign total   = {1'b0, n_reg} + 1'b1;
    assign nxt_pfx = run_reg + PW'($signed(s_value)) - PW'(thr_reg);
    assign a_ok    = a_reg < mid_reg;
    assign b_ok    = b_reg < hi_reg;
    // In ST_CMP, va_reg holds prefix[a] and p_rd holds prefix[b].
    assign take_a  = !b_ok || (a_ok && (va_reg <= $signed(p_rd)));

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_INIT:      st_next = ST_LOAD;
            ST_LOAD:      if (s_valid && s_last) st_next = ST_PASS;
            ST_PASS:      st_next = (width_reg < total) ? ST_FETCH : ST_EMIT;
            ST_FETCH:     st_next = ST_WAIT;
            ST_WAIT:      st_next = ST_CMP;
            ST_CMP:       st_next = (k_reg + 1'b1 >= hi_reg) ? ST_COPY_RD : ST_FETCH;
            ST_COPY_RD:   st_next = ST_COPY_WAIT;
            ST_COPY_WAIT: st_next = ST_COPY_WR;
            ST_COPY_WR: begin
                if (k_reg + 1'b1 < hi_reg) st_next = ST_COPY_RD;
                else if (hi_reg < total) st_next = ST_FETCH;
                else st_next = ST_PASS;
            end
            ST_EMIT:      if (m_ready) st_next = ST_LOAD;
            default:      st_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready = (st_reg == ST_LOAD);
        m_valid = (st_reg == ST_EMIT);
        m_pair_count = acc_reg;
        m_overflow = drop_reg;
        p_we = 1'b0; p_wa = n_reg + 1'b1; p_wd = nxt_pfx;
        p_ra = a_reg[AW-1:0];
        s_we = 1'b0; s_wa = k_reg[AW-1:0]; s_wd = take_a ? va_reg : p_rd;
        s_ra = k_reg[AW-1:0];
        case (st_reg)
            ST_LOAD: begin
                p_we = s_valid && (n_reg < AW'(MAX_ITEMS));
            end
            ST_FETCH:   p_ra = a_reg[AW-1:0];
            ST_WAIT:    p_ra = b_reg[AW-1:0];
            ST_CMP:     s_we = 1'b1;
            ST_COPY_WR: begin
                p_we = 1'b1; p_wa = k_reg[AW-1:0]; p_wd = s_rd;
            end
            default: ;
        endcase
        // Entry zero is written as zero after reset and on emit, so each sequence
        // starts clean.
        if (st_reg == ST_EMIT || st_reg == ST_INIT) begin
            p_we = 1'b1; p_wa = '0; p_wd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_INIT; thr_reg <= '0; run_reg <= '0; n_reg <= '0;
            drop_reg <= 1'b0; acc_reg <= '0; width_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) thr_reg <= cfg_wdata;
            case (st_reg)
                ST_LOAD: if (s_valid) begin
                    if (n_reg < AW'(MAX_ITEMS)) begin
                        run_reg <= nxt_pfx; n_reg <= n_reg + 1'b1;
                    end else drop_reg <= 1'b1;
                    acc_reg <= '0; width_reg <= (AW+1)'(1);
                end
                ST_EMIT: if (m_ready) begin
                    run_reg <= '0; n_reg <= '0; drop_reg <= 1'b0;
                end
                ST_CMP: if (!take_a) acc_reg <= acc_reg + CNT_W'(placed_reg);
                ST_COPY_WR: if (!(k_reg + 1'b1 < hi_reg) && !(hi_reg < total))
                    width_reg <= width_reg << 1;
                default: ;
            endcase
        end
    end

    // Merge pointers; payload-like, no reset needed.
    logic [AW:0] nlo, nmid, nhi;
    always_comb begin
        nlo  = (st_reg == ST_PASS) ? '0 : hi_reg;
        nmid = (nlo + width_reg > total) ? total : nlo + width_reg;
        nhi  = (nlo + (width_reg << 1) > total) ? total : nlo + (width_reg << 1);
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_PASS ||
            (st_reg == ST_COPY_WR && !(k_reg + 1'b1 < hi_reg))) begin
            lo_reg <= nlo; mid_reg <= nmid; hi_reg <= nhi;
            a_reg <= nlo; b_reg <= nmid; k_reg <= nlo; placed_reg <= '0;
        end
        if (st_reg == ST_WAIT) va_reg <= p_rd;
        if (st_reg == ST_CMP) begin
            if (take_a) begin
                a_reg <= a_reg + 1'b1; placed_reg <= placed_reg + 1'b1;
            end else b_reg <= b_reg + 1'b1;
            k_reg <= (k_reg + 1'b1 >= hi_reg) ? lo_reg : k_reg + 1'b1;
        end
        if (st_reg == ST_COPY_WR && k_reg + 1'b1 < hi_reg) k_reg <= k_reg + 1'b1;
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_LOAD) |-> !s_ready) else $error("input taken while busy");
    a_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_CMP) |-> (a_reg <= mid_reg && b_reg <= hi_reg))
        else $error("merge pointer out of run");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= AW'(MAX_ITEMS)) else $error("store count beyond capacity");
endmodule
`default_nettype wire
